[hw/rtl/pfl_pkg.sv]
// shared types and constants for the page free list allocator
`timescale 1ns / 1ps

package pfl_pkg;

   // page numbering
   localparam int PAGE_W    = 10;
   localparam int MAX_PAGES = 2 ** PAGE_W;
   localparam int LINK_W    = PAGE_W + 1;

   // link word codes beside a page number
   localparam logic [LINK_W-1:0] LINK_END    = LINK_W'(MAX_PAGES);
   localparam logic [LINK_W-1:0] LINK_IN_USE = LINK_W'(MAX_PAGES + 1);

   // register file
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FILE_OPEN = 2'd0;

   // request kinds
   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_DISPOSE = 2'd1,
      KIND_GET     = 2'd2
   } kind_type;

   // response status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_CLOSED   = 3'd1,
      ST_INVALID  = 3'd2,
      ST_NOT_USED = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // link memory command from the engine
   typedef struct packed {
      logic              rd_en;
      logic [PAGE_W-1:0] rd_addr;
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      logic [LINK_W-1:0] wr_data;
   } ram_cmd_type;

endpackage

[hw/rtl/pfl_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps

interface pfl_req_if;
   import pfl_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, kind, page_number, input ready);
   modport sink (input valid, kind, page_number, output ready);
endinterface

interface pfl_rsp_if;
   import pfl_pkg::*;

   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic [PAGE_W-1:0] result_page;

   modport source (output valid, status, result_page, input ready);
   modport sink (input valid, status, result_page, output ready);
endinterface

[hw/rtl/pfl_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pfl_csr.sv]
// apb register block holding the file open flag
`timescale 1ns / 1ps

module pfl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pfl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pfl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pfl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic                            file_open
);
   import pfl_pkg::*;

   logic file_open_ff;
   logic file_open_in;
   logic wr_hit;

   // write transfer to the file open register
   assign wr_hit = psel && penable && pwrite && (paddr == CSR_FILE_OPEN);

   always_comb begin
      file_open_in = file_open_ff;
      if (wr_hit) begin
         file_open_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_open_ff <= 1'b0;
      end else begin
         file_open_ff <= file_open_in;
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      if (paddr == CSR_FILE_OPEN) begin
         prdata = {{(CSR_DATA_W-1){1'b0}}, file_open_ff};
      end
   end

   assign pready    = 1'b1;
   assign file_open = file_open_ff;

endmodule

[hw/rtl/pfl_engine.sv]
// request sequencer: reads a link word, updates head, count and links
`timescale 1ns / 1ps

module pfl_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          file_open,
   pfl_req_if.sink                       req_ch,
   pfl_rsp_if.source                     rsp_ch,
   output pfl_pkg::ram_cmd_type          ram_cmd,
   input  logic [pfl_pkg::LINK_W-1:0]    ram_rd_data
);
   import pfl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [PAGE_W-1:0] result_ff, result_in;

   logic              req_xfer;
   logic              head_live;
   status_type        exec_status;
   logic [PAGE_W-1:0] exec_page;
   logic [LINK_W-1:0] exec_head;
   logic [LINK_W-1:0] exec_count;
   logic              exec_wr;
   logic [PAGE_W-1:0] exec_wr_addr;
   logic [LINK_W-1:0] exec_wr_data;

   // accept only when idle and the response slot is free by the next edge
   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign head_live    = (head_ff < LINK_END);

   // link read issued with the request transfer, link write back on execute
   always_comb begin
      ram_cmd.rd_en   = req_xfer;
      ram_cmd.rd_addr = req_ch.page_number;
      if (kind_type'(req_ch.kind) == KIND_ALLOC) begin
         ram_cmd.rd_addr = head_ff[PAGE_W-1:0];
      end
      ram_cmd.wr_en   = (state_ff == S_EXEC) && exec_wr;
      ram_cmd.wr_addr = exec_wr_addr;
      ram_cmd.wr_data = exec_wr_data;
   end

   // request evaluation against the link word read back
   always_comb begin
      exec_status  = ST_OK;
      exec_page    = '0;
      exec_head    = head_ff;
      exec_count   = count_ff;
      exec_wr      = 1'b0;
      exec_wr_addr = page_ff;
      exec_wr_data = LINK_IN_USE;
      if (!file_open) begin
         exec_status = ST_CLOSED;
      end else begin
         case (kind_type'(kind_ff))
            KIND_ALLOC: begin
               if (head_live) begin
                  exec_page    = head_ff[PAGE_W-1:0];
                  exec_wr      = 1'b1;
                  exec_wr_addr = head_ff[PAGE_W-1:0];
                  exec_head    = (ram_rd_data < LINK_END) ? ram_rd_data
                                                          : LINK_END;
               end else if (count_ff < LINK_W'(MAX_PAGES)) begin
                  exec_page    = count_ff[PAGE_W-1:0];
                  exec_wr      = 1'b1;
                  exec_wr_addr = count_ff[PAGE_W-1:0];
                  exec_count   = count_ff + LINK_W'(1);
               end else begin
                  exec_status = ST_FULL;
               end
            end
            KIND_DISPOSE, KIND_GET: begin
               if ({1'b0, page_ff} >= count_ff) begin
                  exec_status = ST_INVALID;
               end else if (ram_rd_data != LINK_IN_USE) begin
                  exec_status = ST_NOT_USED;
               end else if (kind_type'(kind_ff) == KIND_DISPOSE) begin
                  exec_wr      = 1'b1;
                  exec_wr_data = head_ff;
                  exec_head    = {1'b0, page_ff};
               end else begin
                  exec_page = page_ff;
               end
            end
            default: begin
               exec_status = ST_INVALID;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      page_in      = page_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_ch.kind;
               page_in  = req_ch.page_number;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            head_in      = exec_head;
            count_in     = exec_count;
            status_in    = exec_status;
            result_in    = exec_page;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= LINK_END;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      page_ff   <= page_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.result_page = result_ff;

endmodule

[hw/rtl/page_free_list_allocator.sv]
// top level of the lifo free list page allocator
//
//   channel   direction  handshake                 payload
//   req_ch    in         valid / ready             kind, page_number
//   rsp_ch    out        valid / ready             status, result_page
//   csr       in         apb psel/penable/pwrite   file_open at address 0
//
// For each request, the transfer cycle issues the link word read, and the
// next cycle evaluates it, writes the link memory and loads the response
// register. The registered read of the link memory followed by the write
// back sets this order.
// A new request is taken while the previous response still waits, as long
// as that response leaves at the same edge. Reset is synchronous: head goes
// to list end and page count to zero; the link memory is not cleared.
`timescale 1ns / 1ps

module page_free_list_allocator (
   input  logic                            clock,
   input  logic                            reset,
   pfl_req_if.sink                         req_ch,
   pfl_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pfl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pfl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pfl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import pfl_pkg::*;

   logic              file_open;
   ram_cmd_type       ram_cmd;
   logic [LINK_W-1:0] ram_rd_data;

   // configuration registers
   pfl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .file_open (file_open)
   );

   // request sequencer
   pfl_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .file_open   (file_open),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   // per-page link words
   pfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_PAGES)
   ) u_links (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

[hw/rtl/pfl_checker.sv]
// port-level checks for the page allocator, bound to the top level
`timescale 1ns / 1ps

module pfl_port_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [2:0]                   rsp_status,
   input logic [pfl_pkg::PAGE_W-1:0]  rsp_result_page
);
   import pfl_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_result_page))
      else $error("stalled response changed");

   // one request in flight: no transfer in the cycle after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // every request transfer is followed by a valid response after the execute state
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("no response after request transfer");

   // a refused request carries page zero
   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_result_page == '0)
      else $error("nonzero page on failed response");

endmodule

bind page_free_list_allocator pfl_port_checker u_pfl_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_result_page (rsp_ch.result_page)
);

[dv/pfl_checker.sv]
// response checker and page allocator predictor for the free list allocator
`timescale 1ns / 1ps

module pfl_checker
   import pfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pfl_req_if                    req_ch,
   pfl_rsp_if                    rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      status_type        status;
      logic [PAGE_W-1:0] page;
   } page_reply_type;

   // shadow of the allocator state
   logic [LINK_W-1:0] link_words [MAX_PAGES];
   logic [LINK_W-1:0] free_top;
   logic [LINK_W-1:0] pages_made;
   logic              file_is_open;

   page_reply_type expected_replies [$];
   int             errors;

   initial begin
      errors      = 0;
      fail_count  = 0;
      outstanding = 0;
   end

   // work out the reply of one request and update the shadow state
   task automatic serve_request(input logic [1:0] kind, input logic [PAGE_W-1:0] pg);
      page_reply_type    reply;
      logic [LINK_W-1:0] got;
      reply.status = ST_OK;
      reply.page   = '0;
      got          = '0;
      if (!file_is_open) begin
         reply.status = ST_CLOSED;
      end else if (kind == KIND_ALLOC) begin
         if (free_top < MAX_PAGES) begin
            got      = free_top;
            free_top = link_words[got[PAGE_W-1:0]];
            // a corrupt link ends the list
            if (free_top >= MAX_PAGES) free_top = LINK_END;
         end else if (pages_made < MAX_PAGES) begin
            got        = pages_made;
            pages_made = pages_made + 1'b1;
         end else begin
            reply.status = ST_FULL;
         end
         if (reply.status == ST_OK) begin
            link_words[got[PAGE_W-1:0]] = LINK_IN_USE;
            reply.page = got[PAGE_W-1:0];
         end
      end else if ((kind != KIND_DISPOSE && kind != KIND_GET) || pg >= pages_made) begin
         reply.status = ST_INVALID;
      end else if (link_words[pg] != LINK_IN_USE) begin
         reply.status = ST_NOT_USED;
      end else if (kind == KIND_DISPOSE) begin
         link_words[pg] = free_top;
         free_top       = {1'b0, pg};
      end else begin
         reply.page = pg;
      end
      expected_replies.push_back(reply);
   endtask

   // watch register writes, responses and requests
   always @(posedge clock) begin
      page_reply_type want;
      if (reset) begin
         foreach (link_words[i]) link_words[i] = '0;
         free_top     = LINK_END;
         pages_made   = '0;
         file_is_open = 1'b0;
         expected_replies.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_FILE_OPEN)
            file_is_open = pwdata[0];

         // compare a response transfer with the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
               $error("response with nothing expected: status %0d result_page %0d",
                      rsp_ch.status, rsp_ch.result_page);
               errors++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.result_page !== want.page) begin
                  $error("result_page expected %0d actual %0d", want.page,
                         rsp_ch.result_page);
                  errors++;
               end
            end
         end

         if (req_ch.valid && req_ch.ready)
            serve_request(req_ch.kind, req_ch.page_number);
      end
      outstanding <= expected_replies.size();
      fail_count  <= errors;
   end

endmodule

[dv/page_free_list_allocator_test.sv]
// stimulus and verdict for the page free list allocator
`timescale 1ns / 1ps

module page_free_list_allocator_test;
   import pfl_pkg::*;

   // the one two-bit kind code that names no request
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int outstanding;

   // stimulus shaping state
   int   page_hint;
   logic full_seen;
   logic quiet;
   logic stall_go;
   logic stall_done;

   pfl_req_if req_ch ();
   pfl_rsp_if rsp_ch ();

   page_free_list_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   pfl_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // track the page count and the full status from response transfers
   initial begin
      page_hint = 0;
      full_seen = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_ch.status == ST_OK && int'(rsp_ch.result_page) >= page_hint)
               page_hint <= int'(rsp_ch.result_page) + 1;
            if (rsp_ch.status == ST_FULL) full_seen <= 1'b1;
         end
      end
   end

   // response side: random back-pressure and one long hold-off
   initial begin
      stall_done  = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_go && !stall_done) begin
            stall_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // one request transfer, then maybe an idle burst
   task automatic send(input logic [1:0] kind, input logic [PAGE_W-1:0] pg);
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.page_number <= pg;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // wait for every response, then write the file_open register
   task automatic set_file_open(input logic value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_FILE_OPEN;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // page target, mostly below the page count, sometimes at the edge
   function automatic logic [PAGE_W-1:0] pick_page();
      int r;
      r = $urandom_range(0, 9);
      if (page_hint == 0 || r == 0) return PAGE_W'($urandom_range(0, MAX_PAGES - 1));
      if (r == 1) return PAGE_W'(page_hint);
      if (r == 2) return PAGE_W'(page_hint - 1);
      return PAGE_W'($urandom_range(0, page_hint - 1));
   endfunction

   // one random request with the given share of allocations
   task automatic send_random(input int alloc_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
         send(KIND_ALLOC, PAGE_W'($urandom_range(0, MAX_PAGES - 1)));
      else if (r < 97 - (97 - alloc_pct) / 2)
         send(KIND_DISPOSE, pick_page());
      else if (r < 97)
         send(KIND_GET, pick_page());
      else
         send(KIND_UNUSED, pick_page());
   endtask

   initial begin
      int guard;
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_ALLOC;
      req_ch.page_number = '0;
      quiet              = 1'b0;
      stall_go           = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // file closed after reset: every kind is refused
      send(KIND_ALLOC, '0);
      send(KIND_DISPOSE, PAGE_W'(5));
      send(KIND_GET, '1);
      send(KIND_UNUSED, '0);

      set_file_open(1'b1);

      // empty file, unknown kind, allocation, reuse and double dispose
      send(KIND_GET, '0);
      send(KIND_DISPOSE, '1);
      send(KIND_UNUSED, '1);
      send(KIND_ALLOC, '0);
      send(KIND_ALLOC, '0);
      send(KIND_ALLOC, '0);
      send(KIND_GET, PAGE_W'(1));
      send(KIND_DISPOSE, PAGE_W'(1));
      send(KIND_GET, PAGE_W'(1));
      send(KIND_DISPOSE, PAGE_W'(1));
      send(KIND_ALLOC, '0);
      send(KIND_DISPOSE, '0);
      send(KIND_DISPOSE, PAGE_W'(2));
      send(KIND_ALLOC, '0);
      send(KIND_ALLOC, '0);
      send(KIND_ALLOC, '1);
      send(KIND_GET, PAGE_W'(3));
      send(KIND_GET, PAGE_W'(4));

      // closed again with some state in place
      set_file_open(1'b0);
      repeat (8) send_random(40);
      set_file_open(1'b1);

      // mixed traffic that builds a free list, with one long response stall
      for (int n = 0; n < 80; n++) begin
         if (n == 20) stall_go <= 1'b1;
         send_random(45);
      end

      // fill the file to capacity, draining the free list on the way
      guard = 0;
      while (!full_seen && guard < 3000) begin
         if ($urandom_range(0, 19) == 0) send(KIND_GET, pick_page());
         else send(KIND_ALLOC, PAGE_W'($urandom_range(0, MAX_PAGES - 1)));
         guard++;
      end
      repeat (8) send(KIND_ALLOC, PAGE_W'($urandom_range(0, MAX_PAGES - 1)));

      // churn near capacity with no idling
      quiet <= 1'b1;
      repeat (60) send_random(40);

      // drain and settle
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
